// ===== rtl/core/vde_pkg.sv =====
// shared types and constants for the int8 vector distance engine
package vde_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_METRIC = 2'd0;
    localparam logic [1:0] REG_SIGNED = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    // metric codes
    localparam logic [2:0] METRIC_EUCLID  = 3'd0;
    localparam logic [2:0] METRIC_SQ      = 3'd1;
    localparam logic [2:0] METRIC_COSINE  = 3'd2;
    localparam logic [2:0] METRIC_NEG_DOT = 3'd3;
    localparam logic [2:0] METRIC_L1      = 3'd4;

    localparam int DIM_MAX_DEF = 4096;
    localparam int CFG_W       = 13;
    localparam int ACC_P_W     = 30;
    localparam int ACC_N_W     = 29;
    localparam int DIST_W      = 45;

    // root unit: 64-bit radicand, two bits per step
    localparam int ROOT_IN_W  = 64;
    localparam int ROOT_OUT_W = 32;
    localparam int ROOT_REM_W = 34;

    // divider: quotient with 34 fraction bits
    localparam int DIV_NUM_W  = 59;
    localparam int DIV_DEN_W  = 58;
    localparam int DIV_FRAC_W = 34;

    localparam logic [DIST_W-1:0] ONE_Q16 = 45'd65536;

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_FIN,
        ST_MUL_N,
        ST_MUL_D,
        ST_DIV,
        ST_ROOT,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/vde_root.sv =====
// iterative integer square root, two radicand bits per cycle
module vde_root (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [vde_pkg::ROOT_IN_W-1:0]     i_n,
    output vde_pkg::t_unit_stat               o_stat,
    output logic [vde_pkg::ROOT_OUT_W-1:0]    o_root,
    output logic [vde_pkg::ROOT_REM_W-1:0]    o_rem
);
    localparam int CW = $clog2(vde_pkg::ROOT_OUT_W);

    logic [vde_pkg::ROOT_IN_W-1:0]  r_n;
    logic [vde_pkg::ROOT_OUT_W-1:0] r_root;
    logic [vde_pkg::ROOT_REM_W-1:0] r_rem;
    logic [CW-1:0]                  r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [vde_pkg::ROOT_REM_W+1:0] w_cur;
    logic [vde_pkg::ROOT_REM_W+1:0] w_trial;
    logic                           w_ge;

    // one digit step
    assign w_cur   = {r_rem, r_n[vde_pkg::ROOT_IN_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_cur >= w_trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(vde_pkg::ROOT_OUT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_n <= {r_n[vde_pkg::ROOT_IN_W-3:0], 2'b00};
            if (w_ge) begin
                r_rem  <= vde_pkg::ROOT_REM_W'(w_cur - w_trial);
                r_root <= {r_root[vde_pkg::ROOT_OUT_W-2:0], 1'b1};
            end else begin
                r_rem  <= vde_pkg::ROOT_REM_W'(w_cur);
                r_root <= {r_root[vde_pkg::ROOT_OUT_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;
    assign o_rem       = r_rem;

endmodule

// ===== rtl/core/vde_div.sv =====
// restoring divider: saturated quotient num/den with 34 fraction bits
module vde_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [vde_pkg::DIV_NUM_W-1:0]     i_num,
    input  logic [vde_pkg::DIV_DEN_W-1:0]     i_den,
    output vde_pkg::t_unit_stat               o_stat,
    output logic [vde_pkg::DIV_FRAC_W-1:0]    o_q
);
    localparam int CW = $clog2(vde_pkg::DIV_FRAC_W);

    logic [vde_pkg::DIV_DEN_W-1:0]  r_den;
    logic [vde_pkg::DIV_DEN_W-1:0]  r_rem;
    logic [vde_pkg::DIV_FRAC_W-1:0] r_frac;
    logic                           r_sat;
    logic [CW-1:0]                  r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [vde_pkg::DIV_DEN_W:0]    w_rem2;
    logic                           w_ge;
    logic                           w_sat;
    logic                           w_int;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    // quotient of 2 or more saturates, quotient of 1 also lands above range
    assign w_sat  = ({1'b0, i_num} >= {i_den, 1'b0});
    assign w_int  = (i_num >= {1'b0, i_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(vde_pkg::DIV_FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_sat  <= w_sat | w_int;
            r_rem  <= vde_pkg::DIV_DEN_W'(w_int ? (i_num - {1'b0, i_den}) : i_num);
            r_frac <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem  <= vde_pkg::DIV_DEN_W'(w_rem2 - {1'b0, r_den});
                r_frac <= {r_frac[vde_pkg::DIV_FRAC_W-2:0], 1'b1};
            end else begin
                r_rem  <= vde_pkg::DIV_DEN_W'(w_rem2);
                r_frac <= {r_frac[vde_pkg::DIV_FRAC_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_q         = r_sat ? '1 : r_frac;

endmodule

// ===== rtl/core/int8_vector_distance_engine_core.sv =====
// top level of the int8 vector distance engine
//
// Input channel: i_valid / o_stall carry one pair of bytes (i_elem_a, i_elem_b)
// per transfer. Output channel: o_valid / i_stall carry one distance in signed
// Q16 (o_distance) and the zero norm flag, one transfer per finished vector.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data (index 0
// metric, 1 signed elements, 2 vector length); the user must do so only while
// the block is idle, the block itself does not enforce this. Throughput: one
// pair per cycle inside a vector. The last pair starts the finish sequence,
// during which o_stall is high:
//   squared euclidean, manhattan, negated dot: finish and done states only
//   euclidean: 32 steps of the shared root unit
//   cosine: two passes of the shared multiplier, 34 divider and 32 root steps
// The result sits in an output register; while the receiver stalls a new
// vector may stream in, and its finish sequence waits for the register.
// Reset (synchronous, active low) loads metric 1, unsigned elements, length 1
// and clears the sums and the pair count.
module int8_vector_distance_engine_core #(
    parameter int DIM_MAX = vde_pkg::DIM_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [vde_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_elem_a,
    input  logic [7:0]                      i_elem_b,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [vde_pkg::DIST_W-1:0] o_distance,
    output logic                            o_zero_norm
);
    localparam int CNT_W = $clog2(DIM_MAX + 1);
    localparam int LEN_W = (CNT_W > vde_pkg::CFG_W) ? CNT_W : vde_pkg::CFG_W;
    localparam int AW = vde_pkg::ACC_P_W;
    localparam int NW = vde_pkg::ACC_N_W;
    localparam int DW = vde_pkg::DIST_W;
    localparam int DIV_DEN_LOC = vde_pkg::DIV_DEN_W;

    // configuration
    logic [2:0]                r_metric;
    logic                      r_signed;
    logic [vde_pkg::CFG_W-1:0] r_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= vde_pkg::METRIC_SQ;
            r_signed <= 1'b0;
            r_length <= vde_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vde_pkg::REG_METRIC: r_metric <= i_cfg_data[2:0];
                vde_pkg::REG_SIGNED: r_signed <= i_cfg_data[0];
                vde_pkg::REG_LENGTH: r_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vde_pkg::t_state r_state, n_state;

    logic signed [AW-1:0] r_acc_p;
    logic [NW-1:0]        r_acc_a;
    logic [NW-1:0]        r_acc_b;
    logic [CNT_W-1:0]     r_count;
    logic [2:0]           r_fmetric;
    logic                 r_is_cos;
    logic [DIV_DEN_LOC-1:0] r_p;
    logic [DW-1:0]        r_res;
    logic                 r_res_zn;
    logic                 r_ovalid;
    logic [DW-1:0]        r_odist;
    logic                 r_ozn;

    // per-pair terms
    logic signed [8:0]  w_a, w_b;
    logic signed [9:0]  w_d;
    logic signed [17:0] w_ab;
    logic signed [19:0] w_dd;
    logic signed [9:0]  w_absd;
    logic signed [17:0] w_aa, w_bb;
    logic signed [AW-1:0] w_term;
    logic signed [AW-1:0] w_acc_p_nx;
    logic [NW-1:0]      w_acc_a_nx, w_acc_b_nx;
    logic [CNT_W-1:0]   w_count_nx;
    logic [LEN_W-1:0]   w_len;
    logic               w_take;
    logic               w_last;

    assign w_a    = r_signed ? $signed({i_elem_a[7], i_elem_a}) : $signed({1'b0, i_elem_a});
    assign w_b    = r_signed ? $signed({i_elem_b[7], i_elem_b}) : $signed({1'b0, i_elem_b});
    assign w_d    = 10'(w_a) - 10'(w_b);
    assign w_ab   = w_a * w_b;
    assign w_dd   = w_d * w_d;
    assign w_absd = w_d[9] ? -w_d : w_d;
    assign w_aa   = w_a * w_a;
    assign w_bb   = w_b * w_b;

    always_comb begin
        case (r_metric)
            vde_pkg::METRIC_COSINE,
            vde_pkg::METRIC_NEG_DOT: w_term = AW'(w_ab);
            vde_pkg::METRIC_L1:      w_term = AW'(w_absd);
            default:                 w_term = AW'(w_dd);
        endcase
    end

    // effective vector length
    always_comb begin
        if (r_length == '0) begin
            w_len = LEN_W'(1);
        end else if (LEN_W'(r_length) > LEN_W'(DIM_MAX)) begin
            w_len = LEN_W'(DIM_MAX);
        end else begin
            w_len = LEN_W'(r_length);
        end
    end

    assign w_take     = i_valid && !o_stall;
    assign w_acc_p_nx = r_acc_p + w_term;
    assign w_acc_a_nx = r_acc_a + NW'(w_aa[16:0]);
    assign w_acc_b_nx = r_acc_b + NW'(w_bb[16:0]);
    assign w_count_nx = r_count + 1'b1;
    assign w_last     = (LEN_W'(w_count_nx) >= w_len);

    // shared multiplier
    logic [AW-1:0]   w_mag;
    logic [AW-1:0]   w_mop;
    logic [2*AW-1:0] w_prod;

    assign w_mag  = r_acc_p[AW-1] ? AW'(-r_acc_p) : AW'(r_acc_p);
    assign w_mop  = (r_state == vde_pkg::ST_MUL_N) ? AW'(r_acc_a) : w_mag;
    assign w_prod = (r_state == vde_pkg::ST_MUL_N) ? (w_mop * AW'(r_acc_b))
                                                    : (w_mop * w_mop);

    // shared units
    vde_pkg::t_unit_stat              w_root_stat, w_div_stat;
    logic [vde_pkg::ROOT_OUT_W-1:0]   w_root;
    logic [vde_pkg::ROOT_REM_W-1:0]   w_rem;
    logic [vde_pkg::DIV_FRAC_W-1:0]   w_q;
    logic                             w_root_start;
    logic [vde_pkg::ROOT_IN_W-1:0]    w_root_n;
    logic                             w_div_start;

    assign w_div_start  = (r_state == vde_pkg::ST_MUL_D);
    assign w_root_start = ((r_state == vde_pkg::ST_FIN) && (r_fmetric == vde_pkg::METRIC_EUCLID))
                       || ((r_state == vde_pkg::ST_DIV) && w_div_stat.done);
    assign w_root_n     = (r_state == vde_pkg::ST_DIV)
                        ? vde_pkg::ROOT_IN_W'(w_q)
                        : {r_acc_p[AW-1], r_acc_p[AW-1], r_acc_p, 32'b0};

    vde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod[vde_pkg::DIV_NUM_W-1:0]),
        .i_den   (r_p),
        .o_stat  (w_div_stat),
        .o_q     (w_q)
    );

    vde_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_n     (w_root_n),
        .o_stat  (w_root_stat),
        .o_root  (w_root),
        .o_rem   (w_rem)
    );

    // finish results
    logic [DW-1:0] w_simple;
    logic [DW-1:0] w_euclid;
    logic [16:0]   w_cq;
    logic [DW-1:0] w_cos;
    logic [AW-1:0] w_neg;
    logic          w_out_free;

    assign w_neg = AW'(-r_acc_p);
    assign w_simple = (r_fmetric == vde_pkg::METRIC_NEG_DOT) ? {w_neg[AW-2:0], 16'b0}
                                                             : {r_acc_p[AW-2:0], 16'b0};
    assign w_euclid = DW'(w_root) + DW'({1'b0, w_rem} > {3'b0, w_root});
    assign w_cq     = 17'((18'(w_root[16:0]) + 18'd1) >> 1);
    assign w_cos    = r_acc_p[AW-1] ? (vde_pkg::ONE_Q16 + DW'(w_cq))
                                    : (vde_pkg::ONE_Q16 - DW'(w_cq));
    assign w_out_free = !r_ovalid || !i_stall;

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vde_pkg::ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vde_pkg::ST_ACC: begin
                if (w_take && w_last) n_state = vde_pkg::ST_FIN;
            end
            vde_pkg::ST_FIN: begin
                if (r_fmetric == vde_pkg::METRIC_EUCLID) begin
                    n_state = vde_pkg::ST_ROOT;
                end else if (r_fmetric == vde_pkg::METRIC_COSINE &&
                             r_acc_a != '0 && r_acc_b != '0) begin
                    n_state = vde_pkg::ST_MUL_N;
                end else begin
                    n_state = vde_pkg::ST_DONE;
                end
            end
            vde_pkg::ST_MUL_N: n_state = vde_pkg::ST_MUL_D;
            vde_pkg::ST_MUL_D: n_state = vde_pkg::ST_DIV;
            vde_pkg::ST_DIV: begin
                if (w_div_stat.done) n_state = vde_pkg::ST_ROOT;
            end
            vde_pkg::ST_ROOT: begin
                if (w_root_stat.done) n_state = vde_pkg::ST_DONE;
            end
            vde_pkg::ST_DONE: begin
                if (w_out_free) n_state = vde_pkg::ST_ACC;
            end
            default: n_state = vde_pkg::ST_ACC;
        endcase
    end

    // sums and pair count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_p <= '0;
            r_acc_a <= '0;
            r_acc_b <= '0;
            r_count <= '0;
        end else if (w_take) begin
            r_acc_p <= w_acc_p_nx;
            r_acc_a <= w_acc_a_nx;
            r_acc_b <= w_acc_b_nx;
            r_count <= w_last ? '0 : w_count_nx;
        end else if (r_state == vde_pkg::ST_DONE && w_out_free) begin
            r_acc_p <= '0;
            r_acc_a <= '0;
            r_acc_b <= '0;
        end
    end

    // finish datapath
    always_ff @(posedge i_clk) begin
        if (w_take && w_last) begin
            r_fmetric <= r_metric;
        end
        if (r_state == vde_pkg::ST_MUL_N) begin
            r_p <= w_prod[DIV_DEN_LOC-1:0];
        end
        if (r_state == vde_pkg::ST_FIN) begin
            r_is_cos <= (r_fmetric == vde_pkg::METRIC_COSINE);
            r_res    <= (r_fmetric == vde_pkg::METRIC_COSINE) ? vde_pkg::ONE_Q16 : w_simple;
            r_res_zn <= (r_fmetric == vde_pkg::METRIC_COSINE);
        end
        if (r_state == vde_pkg::ST_ROOT && w_root_stat.done) begin
            r_res    <= r_is_cos ? w_cos : w_euclid;
            r_res_zn <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == vde_pkg::ST_DONE && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == vde_pkg::ST_DONE && w_out_free) begin
            r_odist <= r_res;
            r_ozn   <= r_res_zn;
        end
    end

    assign o_stall     = (r_state != vde_pkg::ST_ACC);
    assign o_valid     = r_ovalid;
    assign o_distance  = $signed(r_odist);
    assign o_zero_norm = r_ozn;

`ifndef SYNTH
    // a forced cosine result is exactly one
    a_zero_norm_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_norm) |-> (o_distance == $signed(vde_pkg::ONE_Q16)))
        else $error("zero norm result is not one");

    // the root unit is never restarted while it works
    a_root_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_start |-> !w_root_stat.busy)
        else $error("root unit restarted while busy");

    // the pair count stays below the maximum length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LEN_W'(r_count) < LEN_W'(DIM_MAX)))
        else $error("pair count out of range");

    // a finished vector is followed by the finish sequence
    a_fin_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_last) |=> (r_state == vde_pkg::ST_FIN))
        else $error("finish sequence not entered");
`endif

endmodule

// ===== verif/int8_vector_distance_engine_core_tb.sv =====
// self-checking testbench for the int8 vector distance engine
`timescale 1ns / 1ps

module int8_vector_distance_engine_core_tb;

    // scoreboard: predicts distances from accepted element pairs
    class distance_board;
        logic [2:0]  metric_q;
        logic        signed_q;
        logic [12:0] length_q;
        longint      sum_main;
        longint      sum_norm_a;
        longint      sum_norm_b;
        int          pairs_taken;
        logic [vde_pkg::DIST_W-1:0] dist_queue[$];
        logic                       flag_queue[$];
        int                errors;

        function void clear();
            metric_q = vde_pkg::METRIC_SQ;
            signed_q = 1'b0;
            length_q = 13'd1;
            sum_main = 0;
            sum_norm_a = 0;
            sum_norm_b = 0;
            pairs_taken = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [12:0] val);
            if (idx == vde_pkg::REG_METRIC) metric_q = val[2:0];
            else if (idx == vde_pkg::REG_SIGNED) signed_q = val[0];
            else if (idx == vde_pkg::REG_LENGTH) length_q = val;
        endfunction

        function longint byte_value(logic [7:0] raw);
            longint v;
            v = raw;
            if (signed_q && v >= 128) v -= 256;
            return v;
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned lo, hi, mid;
            lo = 0;
            hi = 64'hFFFF_FFFF;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (mid * mid <= n) lo = mid;
                else hi = mid - 1;
            end
            return lo;
        endfunction

        // rounded |dot| * 2^16 / sqrt(na*nb) by search on squares
        function longint unsigned cos_ratio(longint unsigned mag, longint unsigned na,
                                            longint unsigned nb);
            logic [127:0]    lhs, rhs;
            longint unsigned lo, hi, mid, odd;
            rhs = {64'd0, mag * mag} << 34;
            lo = 0;
            hi = 65536;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                odd = 2 * mid - 1;
                lhs = 128'(odd * odd) * 128'(na * nb);
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
            return lo;
        endfunction

        // note one accepted element pair
        function void note_pair(logic [7:0] ea, logic [7:0] eb);
            longint a, b, d, dist_v;
            longint unsigned len, s, r, q, mag;
            logic zero;
            a = byte_value(ea);
            b = byte_value(eb);
            d = a - b;
            len = length_q;
            if (len == 0) len = 1;
            if (len > vde_pkg::DIM_MAX_DEF) len = vde_pkg::DIM_MAX_DEF;
            if (metric_q == vde_pkg::METRIC_COSINE || metric_q == vde_pkg::METRIC_NEG_DOT)
                sum_main += a * b;
            else if (metric_q == vde_pkg::METRIC_L1) sum_main += (d < 0) ? -d : d;
            else sum_main += d * d;
            sum_norm_a += a * a;
            sum_norm_b += b * b;
            pairs_taken++;
            if (pairs_taken < len) return;
            zero = 1'b0;
            if (metric_q == vde_pkg::METRIC_EUCLID) begin
                s = longint'(sum_main) << 32;
                r = root_floor(s);
                if (s - r * r > r) r++;
                dist_v = r;
            end else if (metric_q == vde_pkg::METRIC_COSINE) begin
                if (sum_norm_a == 0 || sum_norm_b == 0) begin
                    dist_v = 65536;
                    zero = 1'b1;
                end else begin
                    mag = (sum_main < 0) ? -sum_main : sum_main;
                    q = cos_ratio(mag, sum_norm_a, sum_norm_b);
                    dist_v = (sum_main < 0) ? 65536 + q : 65536 - q;
                end
            end else if (metric_q == vde_pkg::METRIC_NEG_DOT) begin
                dist_v = -sum_main * 65536;
            end else begin
                dist_v = sum_main * 65536;
            end
            dist_queue.push_back(dist_v[vde_pkg::DIST_W-1:0]);
            flag_queue.push_back(zero);
            sum_main = 0;
            sum_norm_a = 0;
            sum_norm_b = 0;
            pairs_taken = 0;
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_result(logic [vde_pkg::DIST_W-1:0] act_dist, logic zero);
            logic [vde_pkg::DIST_W-1:0] exp_d;
            logic                       exp_z;
            if (dist_queue.size() == 0) begin
                $error("unexpected result transfer: distance %0d", $signed(act_dist));
                errors++;
                return;
            end
            exp_d = dist_queue.pop_front();
            exp_z = flag_queue.pop_front();
            if (act_dist !== exp_d) begin
                $error("distance: expected %0d actual %0d", $signed(exp_d), $signed(act_dist));
                errors++;
            end
            if (zero !== exp_z) begin
                $error("zero_norm: expected %0b actual %0b", exp_z, zero);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [vde_pkg::CFG_W-1:0] i_cfg_data;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_elem_a;
    logic [7:0]        i_elem_b;
    logic              o_valid;
    logic              i_stall;
    logic signed [vde_pkg::DIST_W-1:0] o_distance;
    logic              o_zero_norm;

    distance_board board;
    bit                idle_ok;

    int8_vector_distance_engine_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_elem_a(i_elem_a), .i_elem_b(i_elem_b),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_distance(o_distance), .o_zero_norm(o_zero_norm)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // random receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= idle_ok && ($urandom_range(99) < 27);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_distance, o_zero_norm);
    end

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        board.set_reg(idx, val);
    endtask

    // one pair transfer, with an optional gap before it
    task automatic send_pair(logic [7:0] ea, logic [7:0] eb);
        while (idle_ok && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_elem_a <= ea;
        i_elem_b <= eb;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_pair(ea, eb);
    endtask

    // wait for all results, then the finish latency, before a register write
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.dist_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_config(logic [2:0] m, logic s, logic [12:0] len);
        drain();
        write_reg(vde_pkg::REG_METRIC, 13'(m));
        write_reg(vde_pkg::REG_SIGNED, 13'(s));
        write_reg(vde_pkg::REG_LENGTH, len);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_vector(int len, int kind);
        logic [7:0] ea, eb;
        for (int k = 0; k < len; k++) begin
            ea = 8'($urandom);
            eb = 8'($urandom);
            if (kind == 1) ea = 8'd0;
            else if (kind == 2) eb = 8'd0;
            else if (kind == 3) begin ea = 8'hFF; eb = 8'h80; end
            else if (kind == 4) eb = ea;
            else if (kind == 5) eb = -ea;
            send_pair(ea, eb);
        end
    endtask

    // run limit
    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int sent;
        int len;
        board = new();
        board.clear();
        idle_ok = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_elem_a = '0;
        i_elem_b = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, extreme bytes, each metric and special case
        send_pair(8'h00, 8'hFF);
        send_pair(8'hFF, 8'h00);
        for (int m = 0; m < 8; m++) begin
            set_config(m[2:0], m[0], 13'd2);
            send_vector(2, 3);
        end
        set_config(vde_pkg::METRIC_COSINE, 1'b1, 13'd2);
        send_vector(2, 1);
        send_vector(2, 2);
        send_vector(2, 4);
        send_vector(2, 5);
        set_config(vde_pkg::METRIC_EUCLID, 1'b0, 13'd0);
        send_vector(1, 3);
        set_config(vde_pkg::METRIC_L1, 1'b1, 13'd40);
        send_vector(40, 3);
        set_config(vde_pkg::METRIC_NEG_DOT, 1'b0, 13'd40);
        send_vector(40, 3);

        // random: mostly short vectors, with a quiet stretch and busy stretches
        sent = 0;
        while (sent < 290) begin
            idle_ok = (sent > 60);
            len = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
            set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 13'(len));
            repeat ($urandom_range(1, 4)) begin
                send_vector(len, $urandom_range(0, 8));
                sent += len;
            end
        end
        idle_ok = 1'b1;
        drain();
        if (board.errors == 0 && board.dist_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/vde_pkg.sv
rtl/core/vde_root.sv
rtl/core/vde_div.sv
rtl/core/int8_vector_distance_engine_core.sv
verif/int8_vector_distance_engine_core_tb.sv
